/* rtl/mlga_pkg.sv */
package mlga_pkg;

    // result codes
    localparam logic [1:0] STATUS_DONE     = 2'd0;
    localparam logic [1:0] STATUS_CONFLICT = 2'd1;
    localparam logic [1:0] STATUS_FULL     = 2'd2;

    // configuration register indexes
    localparam int         CFG_INDEX_BITS  = 2;
    localparam logic [1:0] REG_USAGE_MAP   = 2'd0;
    localparam logic [1:0] REG_LOCK_ENABLE = 2'd1;

    // fixed field widths
    localparam int USAGE_BITS  = 64;
    localparam int ENABLE_BITS = 8;
    localparam int STREAM_BITS = 3;
    localparam int JOB_BITS    = 32;
    localparam int STATUS_BITS = 2;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       hold_step;
        logic       scan;
        logic       next_lock;
        logic       finish;
        logic [1:0] status;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_release;
        logic conflict;
        logic full;
        logic rel_hit;
        logic match;
        logic scan_end;
        logic lock_last;
    } sts_t;

endpackage

/* rtl/mlga_ram.sv */
module mlga_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/mlga_ctrl.sv */
module mlga_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    output logic           done,
    output mlga_pkg::cmd_t cmd,
    input  mlga_pkg::sts_t sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_HOLD_LOCK,
        S_REL_LOCK,
        S_REL_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;

    // command decode and next state
    always_comb
    begin
        cmd        = '0;
        cmd.status = mlga_pkg::STATUS_DONE;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.is_release)
                begin
                    state_next = S_REL_LOCK;
                end
                else if (sts.conflict)
                begin
                    cmd.finish = 1'b1;
                    cmd.status = mlga_pkg::STATUS_CONFLICT;
                    state_next = S_IDLE;
                end
                else if (sts.full)
                begin
                    cmd.finish = 1'b1;
                    cmd.status = mlga_pkg::STATUS_FULL;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_HOLD_LOCK;
                end
            end
            S_HOLD_LOCK:
            begin
                cmd.hold_step = 1'b1;
                cmd.next_lock = 1'b1;
                if (sts.lock_last)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_REL_LOCK:
            begin
                if (sts.rel_hit)
                begin
                    state_next = S_REL_SCAN;
                end
                else
                begin
                    cmd.next_lock = 1'b1;
                    if (sts.lock_last)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_REL_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.match || sts.scan_end)
                begin
                    cmd.next_lock = 1'b1;
                    if (sts.lock_last)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_REL_LOCK;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.finish;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

/* rtl/mlga_dp.sv */
module mlga_dp #(
    parameter int LOCKS   = 8,
    parameter int STREAMS = 8,
    parameter int HOLDERS = 8,
    parameter int ID_BITS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mlga_pkg::cmd_t                       cmd,
    output mlga_pkg::sts_t                       sts,
    input  logic                                 action,
    input  logic [mlga_pkg::STREAM_BITS-1:0]     stream_num,
    input  logic [mlga_pkg::JOB_BITS-1:0]        job_id,
    input  logic                                 cfg_we,
    input  logic [mlga_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [mlga_pkg::USAGE_BITS-1:0]      cfg_wdata,
    output logic [mlga_pkg::STATUS_BITS-1:0]     status,
    output logic [mlga_pkg::ENABLE_BITS-1:0]     changed_locks
);

    localparam int ID_W  = (ID_BITS < mlga_pkg::JOB_BITS) ? ID_BITS : mlga_pkg::JOB_BITS;
    localparam int LW    = $clog2(LOCKS);
    localparam int SW    = (HOLDERS > 1) ? $clog2(HOLDERS) : 1;
    localparam int CW    = $clog2(HOLDERS + 1);
    localparam int DEPTH = LOCKS * HOLDERS;
    localparam int AW    = $clog2(DEPTH);
    localparam int SB    = mlga_pkg::STREAM_BITS;

    // configuration
    logic [mlga_pkg::USAGE_BITS-1:0]  usage_reg;
    logic [mlga_pkg::ENABLE_BITS-1:0] enable_reg;

    // current request
    logic            action_reg;
    logic [SB-1:0]   stream_reg;
    logic [ID_W-1:0] id_reg;

    // walk counters and scan pipeline
    logic [LW-1:0]   lk_reg;
    logic [CW-1:0]   slot_reg;
    logic            pend_reg;
    logic [SW-1:0]   pslot_reg;
    logic            pvalid_reg;

    // lock state
    logic [SB-1:0]      owner_num_reg   [LOCKS];
    logic [LOCKS-1:0]   owner_valid_reg;
    logic [HOLDERS-1:0] hvalid_reg      [LOCKS];
    logic [CW-1:0]      count_reg       [LOCKS];

    // result
    logic [mlga_pkg::ENABLE_BITS-1:0] changed_reg;
    logic [mlga_pkg::STATUS_BITS-1:0] status_reg;

    logic [LOCKS-1:0][7:0] usage_rows;
    logic [LOCKS-1:0]      needed;
    logic [LOCKS-1:0]      conflict_vec;
    logic [LOCKS-1:0]      full_vec;
    logic                  stream_ok;
    logic [HOLDERS-1:0]    cur_valid;
    logic [CW-1:0]         cur_count;
    logic                  cur_owned;
    logic [SW-1:0]         free_slot;
    logic [SW-1:0]         slot_idx;
    logic                  issue;
    logic [AW-1:0]         base;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic                  wr_en;
    logic [ID_W-1:0]       rd_data;
    logic                  match;

    // which locks the request needs, and the hold checks
    assign stream_ok = ({1'b0, stream_reg} < (SB + 1)'(STREAMS));

    always_comb
    begin
        for (int l = 0; l < LOCKS; l++)
        begin
            usage_rows[l]   = usage_reg[8*l +: 8];
            needed[l]       = enable_reg[l] && stream_ok && usage_rows[l][stream_reg];
            conflict_vec[l] = needed[l] && owner_valid_reg[l]
                              && (owner_num_reg[l] != stream_reg);
            full_vec[l]     = needed[l] && (count_reg[l] == CW'(HOLDERS));
        end
    end

    // current lock view
    assign cur_valid = hvalid_reg[lk_reg];
    assign cur_count = count_reg[lk_reg];
    assign cur_owned = owner_valid_reg[lk_reg] && (owner_num_reg[lk_reg] == stream_reg);

    // lowest free holder slot of the current lock
    always_comb
    begin
        free_slot = '0;
        for (int h = HOLDERS - 1; h >= 0; h--)
        begin
            if (!cur_valid[h])
            begin
                free_slot = SW'(h);
            end
        end
    end

    // holder id memory addressing
    assign slot_idx = slot_reg[SW-1:0];
    assign issue    = cmd.scan && (slot_reg < CW'(HOLDERS));
    assign base     = AW'(lk_reg) * AW'(HOLDERS);
    assign rd_addr  = base + AW'(slot_idx);
    assign wr_addr  = base + AW'(free_slot);
    assign wr_en    = cmd.hold_step && needed[lk_reg];

    mlga_ram #(
        .WIDTH (ID_W),
        .DEPTH (DEPTH)
    ) u_ids (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (id_reg),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign match = pend_reg && pvalid_reg && (rd_data == id_reg);

    // status to controller
    always_comb
    begin
        sts            = '0;
        sts.is_release = action_reg;
        sts.conflict   = |conflict_vec;
        sts.full       = |full_vec;
        sts.rel_hit    = needed[lk_reg] && cur_owned;
        sts.match      = match;
        sts.scan_end   = pend_reg && !match && (pslot_reg == SW'(HOLDERS - 1));
        sts.lock_last  = (lk_reg == LW'(LOCKS - 1));
    end

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            usage_reg       <= '0;
            enable_reg      <= '0;
            action_reg      <= 1'b0;
            stream_reg      <= '0;
            id_reg          <= '0;
            lk_reg          <= '0;
            slot_reg        <= '0;
            pend_reg        <= 1'b0;
            pslot_reg       <= '0;
            pvalid_reg      <= 1'b0;
            owner_valid_reg <= '0;
            changed_reg     <= '0;
            status_reg      <= mlga_pkg::STATUS_DONE;
            for (int l = 0; l < LOCKS; l++)
            begin
                owner_num_reg[l] <= '0;
                hvalid_reg[l]    <= '0;
                count_reg[l]     <= '0;
            end
        end
        else
        begin
            // configuration writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    mlga_pkg::REG_USAGE_MAP:   usage_reg  <= cfg_wdata;
                    mlga_pkg::REG_LOCK_ENABLE: enable_reg <= cfg_wdata[mlga_pkg::ENABLE_BITS-1:0];
                    default: ;
                endcase
            end

            // request capture
            if (cmd.load)
            begin
                action_reg  <= action;
                stream_reg  <= stream_num;
                id_reg      <= job_id[ID_W-1:0];
                lk_reg      <= '0;
                slot_reg    <= '0;
                pend_reg    <= 1'b0;
                changed_reg <= '0;
            end

            // hold adds one holder to a needed lock
            if (wr_en)
            begin
                hvalid_reg[lk_reg][free_slot] <= 1'b1;
                count_reg[lk_reg]             <= cur_count + CW'(1);
                owner_valid_reg[lk_reg]       <= 1'b1;
                owner_num_reg[lk_reg]         <= stream_reg;
                changed_reg[lk_reg]           <= 1'b1;
            end

            // release frees the lowest matching holder
            if (cmd.scan && match)
            begin
                hvalid_reg[lk_reg][pslot_reg] <= 1'b0;
                count_reg[lk_reg]             <= cur_count - CW'(1);
                changed_reg[lk_reg]           <= 1'b1;
                if (cur_count == CW'(1))
                begin
                    owner_valid_reg[lk_reg] <= 1'b0;
                    owner_num_reg[lk_reg]   <= '0;
                end
            end

            // lock walk and slot scan
            if (cmd.next_lock)
            begin
                if (lk_reg != LW'(LOCKS - 1))
                begin
                    lk_reg <= lk_reg + LW'(1);
                end
                slot_reg <= '0;
                pend_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                if (issue)
                begin
                    slot_reg <= slot_reg + CW'(1);
                end
                pend_reg   <= issue;
                pslot_reg  <= slot_idx;
                pvalid_reg <= cur_valid[slot_idx];
            end

            // result code
            if (cmd.finish)
            begin
                status_reg <= cmd.status;
            end
        end
    end

    assign status        = status_reg;
    assign changed_locks = changed_reg;

endmodule

/* rtl/multi_lock_group_acquire_top.sv */
// channel   ports                                      beat taken when
// request   start, busy, action, stream_num, job_id   start high and busy low
// config    cfg_we, cfg_index, cfg_wdata               cfg_we high
// result    done, status, changed_locks                done high, one cycle
//
// a granted hold runs one check state, then visits each lock in turn in the hold
// state before the done edge; a refused hold answers straight from the check state
// a release walks every lock and scans the holder id memory for each owned
// needed lock, one slot per cycle, until a matching id or the last slot
// reset clears configuration, owners and holder valid bits at once
// the receiver cannot stall: each result beat is shown for one cycle only
module multi_lock_group_acquire_top #(
    parameter int LOCKS   = 8,
    parameter int STREAMS = 8,
    parameter int HOLDERS = 8,
    parameter int ID_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                action,
    input  logic [mlga_pkg::STREAM_BITS-1:0]    stream_num,
    input  logic [mlga_pkg::JOB_BITS-1:0]       job_id,
    input  logic                                cfg_we,
    input  logic [mlga_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [mlga_pkg::USAGE_BITS-1:0]     cfg_wdata,
    output logic                                done,
    output logic [mlga_pkg::STATUS_BITS-1:0]    status,
    output logic [mlga_pkg::ENABLE_BITS-1:0]    changed_locks
);

    mlga_pkg::cmd_t cmd;
    mlga_pkg::sts_t sts;

    // sequencing
    mlga_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .sts   (sts)
    );

    // lock state and holder lists
    mlga_dp #(
        .LOCKS   (LOCKS),
        .STREAMS (STREAMS),
        .HOLDERS (HOLDERS),
        .ID_BITS (ID_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .action        (action),
        .stream_num    (stream_num),
        .job_id        (job_id),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .status        (status),
        .changed_locks (changed_locks)
    );

endmodule
